// ===== rtl/arfip_pkg.sv =====
package arfip_pkg;

    localparam int DEF_RAM_BYTES = 2048;
    localparam int DEF_REG_BASE  = 2048;
    localparam int DEF_REG_WORDS = 256;
    localparam int SUB_WORDS     = 256;
    localparam int SUB_AW        = 8;

    localparam logic [31:0] VERSION_VALUE = 32'h0001_0000;
    localparam int AI_READ_BIT  = 31;
    localparam int TOG_PLL_BIT  = 24;
    localparam int DONE_PLL_BIT = 25;
    localparam int TOG_PHY_BIT  = 26;
    localparam int DONE_PHY_BIT = 27;

    localparam logic [15:0] FIFO_RX   = 16'h0c00;
    localparam logic [15:0] FIFO_TX   = 16'h0e00;
    localparam logic [15:0] OFS_CTRL  = 16'h0090;
    localparam logic [15:0] OFS_WDATA = 16'h00a0;
    localparam logic [15:0] OFS_RDATA = 16'h00a4;

    localparam logic [3:0] SUB_SET = 4'h4;
    localparam logic [3:0] SUB_CLR = 4'h8;
    localparam logic [3:0] SUB_TOG = 4'hc;

    localparam logic [13:0] CTRL_WORD  = OFS_CTRL[15:2];
    localparam logic [13:0] WDATA_WORD = OFS_WDATA[15:2];
    localparam logic [13:0] RDATA_WORD = OFS_RDATA[15:2];

    typedef enum logic [1:0] {
        C_NONE,
        C_RAM,
        C_REG
    } t_cls;

    typedef enum logic [1:0] {
        W_PLAIN,
        W_SET,
        W_CLR,
        W_TOG
    } t_wop;

    typedef enum logic [1:0] {
        T_MEM,
        T_CTRL,
        T_WDATA,
        T_RDATA
    } t_tgt;

    typedef struct packed {
        t_cls             cls;
        logic             wr;
        t_tgt             tgt;
        t_wop             wop;
        logic [13:0]      tgt_word;
        logic [3:0]       lane_en;
        logic [1:0]       shift;
        logic [3:0]       bank_en;
        logic [3:0][13:0] bank_row;
        logic [3:0][7:0]  bank_wdata;
        logic [31:0]      wdata;
    } t_op;

    function automatic logic [31:0] wop_apply(t_wop w, logic [31:0] old, logic [31:0] v);
        logic [31:0] r;
        unique case (w)
            W_PLAIN: r = v;
            W_SET:   r = old | v;
            W_CLR:   r = old & ~v;
            W_TOG:   r = old ^ v;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] done_fix(logic [31:0] c);
        logic [31:0] r;
        r = c;
        r[DONE_PLL_BIT] = c[TOG_PLL_BIT];
        r[DONE_PHY_BIT] = c[TOG_PHY_BIT];
        return r;
    endfunction

endpackage

// ===== rtl/arfip_front.sv =====
module arfip_front
    import arfip_pkg::*;
#(
    parameter int RAM_BYTES = DEF_RAM_BYTES,
    parameter int REG_BASE  = DEF_REG_BASE,
    parameter int REG_WORDS = DEF_REG_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [15:0] i_offset,
    input  logic [2:0]  i_size,
    input  logic [31:0] i_wdata,
    output logic        o_push,
    output t_op         o_op,
    input  logic        i_q_full
);

    localparam logic [16:0] BASE17  = 17'(REG_BASE);
    localparam logic [16:0] RAM_END = 17'(RAM_BYTES);
    localparam logic [14:0] WORDS15 = 15'(REG_WORDS);

    logic r_valid;
    t_op  r_op;
    t_op  dec;

    always_comb begin
        logic [16:0] ofs17;
        logic [16:0] addr_b;
        logic [2:0]  sz;
        logic [15:0] rel;
        logic [3:0]  sub;
        logic        alias_hit;
        logic [3:0]  en;
        logic [1:0]  bk;
        dec       = '0;
        dec.wr    = i_kind;
        dec.wdata = i_wdata;
        dec.shift = i_offset[1:0];
        ofs17     = {1'b0, i_offset};
        sz        = (i_size > 3'd4) ? 3'd4 : i_size;
        for (int b = 0; b < 4; b++) begin
            addr_b = ofs17 + 17'(b);
            en[b]  = (3'(b) < sz) && (addr_b < RAM_END);
        end
        dec.lane_en = en;
        for (int k = 0; k < 4; k++) begin
            bk                 = 2'(k) - i_offset[1:0];
            addr_b             = ofs17 + {15'd0, bk};
            dec.bank_row[k]    = addr_b[15:2];
            dec.bank_en[k]     = en[bk];
            dec.bank_wdata[k]  = i_wdata[{bk, 3'b000} +: 8];
        end
        rel       = 16'(ofs17 - BASE17);
        sub       = rel[3:0];
        alias_hit = (rel != OFS_WDATA) && (rel != OFS_RDATA) &&
                    (sub == SUB_SET || sub == SUB_CLR || sub == SUB_TOG);
        dec.tgt_word = alias_hit ? {rel[15:4], 2'b00} : rel[15:2];
        if (!alias_hit) begin
            dec.wop = W_PLAIN;
        end else if (sub == SUB_SET) begin
            dec.wop = W_SET;
        end else if (sub == SUB_CLR) begin
            dec.wop = W_CLR;
        end else begin
            dec.wop = W_TOG;
        end
        if (dec.tgt_word == CTRL_WORD) begin
            dec.tgt = T_CTRL;
        end else if (dec.tgt_word == WDATA_WORD) begin
            dec.tgt = T_WDATA;
        end else if (dec.tgt_word == RDATA_WORD) begin
            dec.tgt = T_RDATA;
        end else begin
            dec.tgt = T_MEM;
        end
        priority if (ofs17 < BASE17) begin
            dec.cls = C_RAM;
        end else if (i_offset == FIFO_RX || i_offset == FIFO_TX) begin
            dec.cls = C_NONE;
        end else if ({1'b0, rel[15:2]} >= WORDS15) begin
            dec.cls = C_NONE;
        end else begin
            dec.cls = C_REG;
        end
    end

    assign o_stall = r_valid && i_q_full;
    assign o_push  = r_valid && !i_q_full;
    assign o_op    = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op <= dec;
        end
    end

endmodule

// ===== rtl/arfip_queue.sv =====
module arfip_queue
    import arfip_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);

    t_op        r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ===== rtl/arfip_back.sv =====
module arfip_back
    import arfip_pkg::*;
#(
    parameter int RAM_BYTES = DEF_RAM_BYTES,
    parameter int REG_WORDS = DEF_REG_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_op         i_q_op,
    output logic        o_q_pop,
    output logic        o_clearing,
    output logic        o_valid,
    output logic [31:0] o_rdata,
    input  logic        i_stall
);

    localparam int RAM_ROWS = (RAM_BYTES + 3) / 4;
    localparam int ROW_W    = $clog2(RAM_ROWS);
    localparam int REG_AW   = $clog2(REG_WORDS);
    localparam int LEN_A    = (RAM_ROWS > REG_WORDS) ? RAM_ROWS : REG_WORDS;
    localparam int CLR_LEN  = (LEN_A > SUB_WORDS) ? LEN_A : SUB_WORDS;
    localparam int CLR_W    = $clog2(CLR_LEN);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_RUN,
        S_RAMRD,
        S_REGRD,
        S_RMW,
        S_SUBRD
    } t_state;

    t_state      r_state,     n_state;
    logic [CLR_W-1:0] r_clr_idx, n_clr_idx;
    t_op         r_op,        n_op;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_rdata, n_out_rdata;
    logic [31:0] r_ctrl,      n_ctrl;
    logic [31:0] r_wdata,     n_wdata;
    logic [31:0] r_rdata,     n_rdata;

    logic [3:0]       bank_we;
    logic [ROW_W-1:0] bank_wa [4];
    logic [ROW_W-1:0] bank_ra [4];
    logic [7:0]       bank_wd [4];
    logic [7:0]       bank_q  [4];

    logic              creg_we;
    logic [REG_AW-1:0] creg_wa;
    logic [31:0]       creg_wd;
    logic [31:0]       r_creg_q;
    logic [31:0]       r_creg_mem [REG_WORDS];

    logic              sub_we;
    logic [SUB_AW-1:0] sub_wa;
    logic [SUB_AW-1:0] sub_ra;
    logic [31:0]       sub_wd;
    logic [31:0]       r_sub_q;
    logic [31:0]       r_sub_mem [SUB_WORDS];

    logic        out_free;
    logic [31:0] ctrl_new;
    logic        clr_last;

    assign out_free   = !r_out_valid || !i_stall;
    assign ctrl_new   = wop_apply(i_q_op.wop, r_ctrl, i_q_op.wdata);
    assign sub_ra     = ctrl_new[SUB_AW-1:0];
    assign clr_last   = (r_clr_idx == CLR_W'(CLR_LEN - 1));
    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_rdata    = r_out_rdata;

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0] r_bank_mem [RAM_ROWS];
        logic [7:0] r_q;
        always_ff @(posedge i_clk) begin
            if (bank_we[k]) begin
                r_bank_mem[bank_wa[k]] <= bank_wd[k];
            end
            r_q <= r_bank_mem[bank_ra[k]];
        end
        assign bank_q[k]  = r_q;
        assign bank_ra[k] = i_q_op.bank_row[k][ROW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (creg_we) begin
            r_creg_mem[creg_wa] <= creg_wd;
        end
        r_creg_q <= r_creg_mem[i_q_op.tgt_word[REG_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sub_we) begin
            r_sub_mem[sub_wa] <= sub_wd;
        end
        r_sub_q <= r_sub_mem[sub_ra];
    end

    always_comb begin
        logic [31:0] asm;
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_op        = r_op;
        n_out_valid = r_out_valid && i_stall;
        n_out_rdata = r_out_rdata;
        n_ctrl      = r_ctrl;
        n_wdata     = r_wdata;
        n_rdata     = r_rdata;
        o_q_pop     = 1'b0;
        bank_we     = '0;
        for (int k = 0; k < 4; k++) begin
            bank_wa[k] = i_q_op.bank_row[k][ROW_W-1:0];
            bank_wd[k] = i_q_op.bank_wdata[k];
        end
        creg_we = 1'b0;
        creg_wa = i_q_op.tgt_word[REG_AW-1:0];
        creg_wd = i_q_op.wdata;
        sub_we  = 1'b0;
        sub_wa  = ctrl_new[SUB_AW-1:0];
        sub_wd  = r_wdata;
        asm     = '0;
        unique case (r_state)
            S_CLEAR: begin
                if ({1'b0, r_clr_idx} < (CLR_W + 1)'(RAM_ROWS)) begin
                    bank_we = '1;
                end
                for (int k = 0; k < 4; k++) begin
                    bank_wa[k] = r_clr_idx[ROW_W-1:0];
                    bank_wd[k] = '0;
                end
                creg_we = ({1'b0, r_clr_idx} < (CLR_W + 1)'(REG_WORDS));
                creg_wa = r_clr_idx[REG_AW-1:0];
                creg_wd = (r_clr_idx == '0) ? VERSION_VALUE : '0;
                sub_we  = 1'b1;
                sub_wa  = r_clr_idx[SUB_AW-1:0];
                sub_wd  = '0;
                n_clr_idx = r_clr_idx + CLR_W'(1);
                if (clr_last) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_q_valid && out_free) begin
                    o_q_pop     = 1'b1;
                    n_op        = i_q_op;
                    n_out_rdata = '0;
                    n_out_valid = 1'b1;
                    unique case (i_q_op.cls)
                        C_NONE: begin
                        end
                        C_RAM: begin
                            if (i_q_op.wr) begin
                                bank_we = i_q_op.bank_en;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_RAMRD;
                            end
                        end
                        C_REG: begin
                            if (!i_q_op.wr) begin
                                unique case (i_q_op.tgt)
                                    T_MEM: begin
                                        n_out_valid = 1'b0;
                                        n_state     = S_REGRD;
                                    end
                                    T_CTRL:  n_out_rdata = r_ctrl;
                                    T_WDATA: n_out_rdata = r_wdata;
                                    T_RDATA: n_out_rdata = r_rdata;
                                endcase
                            end else begin
                                unique case (i_q_op.tgt)
                                    T_MEM: begin
                                        if (i_q_op.wop == W_PLAIN) begin
                                            creg_we = 1'b1;
                                        end else begin
                                            n_state = S_RMW;
                                        end
                                    end
                                    T_CTRL: begin
                                        // indirect sub-register access
                                        n_ctrl = done_fix(ctrl_new);
                                        if (ctrl_new[AI_READ_BIT]) begin
                                            n_state = S_SUBRD;
                                        end else begin
                                            sub_we = 1'b1;
                                        end
                                    end
                                    T_WDATA: begin
                                        n_wdata = wop_apply(i_q_op.wop, r_wdata, i_q_op.wdata);
                                    end
                                    T_RDATA: begin
                                        n_rdata = wop_apply(i_q_op.wop, r_rdata, i_q_op.wdata);
                                    end
                                endcase
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RAMRD: begin
                for (int b = 0; b < 4; b++) begin
                    if (r_op.lane_en[b]) begin
                        asm[8*b +: 8] = bank_q[2'(r_op.shift + 2'(b))];
                    end
                end
                n_out_valid = 1'b1;
                n_out_rdata = asm;
                n_state     = S_RUN;
            end
            S_REGRD: begin
                n_out_valid = 1'b1;
                n_out_rdata = r_creg_q;
                n_state     = S_RUN;
            end
            S_RMW: begin
                creg_we = 1'b1;
                creg_wa = r_op.tgt_word[REG_AW-1:0];
                creg_wd = wop_apply(r_op.wop, r_creg_q, r_op.wdata);
                n_state = S_RUN;
            end
            S_SUBRD: begin
                n_rdata = r_sub_q;
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_ctrl      <= '0;
            r_wdata     <= '0;
            r_rdata     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
            r_ctrl      <= n_ctrl;
            r_wdata     <= n_wdata;
            r_rdata     <= n_rdata;
        end
        r_op        <= n_op;
        r_out_rdata <= n_out_rdata;
    end

endmodule

// ===== rtl/alias_register_file_with_indirect_port_core.sv =====
// The input is registered in the front end, passes a two-entry queue and is executed by the
// back end into a registered result; RAM and register-file reads add a registered memory read.
// One item per cycle while no stall is raised; RAM reads, register-file reads, alias
// read-modify-writes and indirect reads each take an extra back-end state before the next item.
// Reset (synchronous, active low) starts a clearing pass of max(ceil(RAM_BYTES/4), REG_WORDS,
// 256) rows (512 by default) during which items queue but are not executed.
module alias_register_file_with_indirect_port_core
    import arfip_pkg::*;
#(
    parameter int RAM_BYTES = DEF_RAM_BYTES,
    parameter int REG_BASE  = DEF_REG_BASE,
    parameter int REG_WORDS = DEF_REG_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [15:0] i_offset,
    input  logic [2:0]  i_size,
    input  logic [31:0] i_wdata,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_rdata
);

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic clearing;
    t_op  push_op;
    t_op  q_op;

    arfip_front #(
        .RAM_BYTES (RAM_BYTES),
        .REG_BASE  (REG_BASE),
        .REG_WORDS (REG_WORDS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_offset (i_offset),
        .i_size   (i_size),
        .i_wdata  (i_wdata),
        .o_push   (q_push),
        .o_op     (push_op),
        .i_q_full (q_full)
    );

    arfip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    arfip_back #(
        .RAM_BYTES (RAM_BYTES),
        .REG_WORDS (REG_WORDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_op     (q_op),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_rdata    (o_rdata),
        .i_stall    (i_stall)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    a_clear_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !q_pop)
        else $error("item executed during clearing pass");

    a_clear_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |=> !o_valid)
        else $error("result produced during clearing pass");
`endif

endmodule
